// ===== sv/pus_pkg.sv =====
// ----------------------------------------------------------------------------
// pus_pkg
// shared types and constants of the streaming pkcs7 unpadder
// ----------------------------------------------------------------------------
package pus_pkg;

    localparam int BLOCK_DEFAULT    = 16;
    localparam int LEN_BITS_DEFAULT = 16;
    localparam int BYTE_W           = 8;
    localparam int LEN_OUT_W        = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_BAD_PAD  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FLUSH
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic push;     // non-final beat accepted
        logic finish;   // final beat accepted
        logic check;    // evaluate the trailer
        logic emit;     // move one held byte to the output register
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
        logic last_emit; // one byte left to flush
    } dp_stat_t;

endpackage

// ===== sv/pkcs7_unpad_stream.sv =====
// ----------------------------------------------------------------------------
// pkcs7_unpad_stream
// streaming pkcs7 unpadding with trailer check and length report
//
//   channel   direction   handshake             payload
//   in        sink        in_valid / in_ready   data_byte, last
//   out       source      out_valid / out_ready out_byte, is_padding, run_end,
//                                               msg_length, status
//
// one beat per cycle while a message streams and the output register is free;
// the final beat is followed by the trailer check, then the flush of the
// hold_count+1 held bytes (at most BLOCK) through the single output register,
// which shifts the hold window out one byte at a time; in_ready is low during
// check and flush, and while the output register is full and not being taken
// reset clears counters and control state; window contents need no reset
// ----------------------------------------------------------------------------
module pkcs7_unpad_stream #(
    parameter int BLOCK    = pus_pkg::BLOCK_DEFAULT,
    parameter int LEN_BITS = pus_pkg::LEN_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pus_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pus_pkg::BYTE_W-1:0]    out_byte,
    output logic                          is_padding,
    output logic                          run_end,
    output logic [pus_pkg::LEN_OUT_W-1:0] msg_length,
    output logic [1:0]                    status
);

    pus_pkg::ctrl_cmd_t cmd;
    pus_pkg::dp_stat_t  stat;

    pus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pus_datapath #(
        .BLOCK    (BLOCK),
        .LEN_BITS (LEN_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_padding (is_padding),
        .run_end    (run_end),
        .msg_length (msg_length),
        .status     (status)
    );

endmodule

// ===== sv/pus_ctrl.sv =====
// ----------------------------------------------------------------------------
// pus_ctrl
// sequencer: streaming, trailer check and flush of the held bytes
// ----------------------------------------------------------------------------
module pus_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last,
    output logic                in_ready,
    input  pus_pkg::dp_stat_t   stat,
    output pus_pkg::ctrl_cmd_t  cmd
);

    pus_pkg::state_t state_reg;
    pus_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pus_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            pus_pkg::S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = pus_pkg::S_CHECK;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            pus_pkg::S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = pus_pkg::S_FLUSH;
            end
            pus_pkg::S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_emit)
                    begin
                        state_next = pus_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pus_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pus_datapath.sv =====
// ----------------------------------------------------------------------------
// pus_datapath
// hold window, byte counter, trailer check and output register
// ----------------------------------------------------------------------------
module pus_datapath #(
    parameter int BLOCK    = pus_pkg::BLOCK_DEFAULT,
    parameter int LEN_BITS = pus_pkg::LEN_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pus_pkg::ctrl_cmd_t            cmd,
    output pus_pkg::dp_stat_t             stat,
    input  logic [pus_pkg::BYTE_W-1:0]    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pus_pkg::BYTE_W-1:0]    out_byte,
    output logic                          is_padding,
    output logic                          run_end,
    output logic [pus_pkg::LEN_OUT_W-1:0] msg_length,
    output logic [1:0]                    status
);

    localparam int HW = $clog2(BLOCK);
    localparam int NW = $clog2(BLOCK + 1);
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // window: BLOCK-1 held bytes plus a slot for the final byte
    logic [pus_pkg::BYTE_W-1:0] win_reg  [BLOCK];
    logic [pus_pkg::BYTE_W-1:0] win_next [BLOCK];
    logic [HW-1:0]              hold_count_reg, hold_count_next;
    logic [LEN_BITS-1:0]        byte_count_reg, byte_count_next;
    logic                       count_overflow_reg, count_overflow_next;
    logic [NW-1:0]              rem_reg, rem_next;
    logic [pus_pkg::BYTE_W-1:0] pad_reg, pad_next;
    pus_pkg::status_t           chk_status_reg, chk_status_next;
    logic [LEN_BITS-1:0]        chk_len_reg, chk_len_next;

    logic                       out_valid_reg, out_valid_next;
    logic [pus_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       is_padding_reg, is_padding_next;
    logic                       run_end_reg, run_end_next;
    logic [pus_pkg::LEN_OUT_W-1:0] msg_length_reg, msg_length_next;
    pus_pkg::status_t           status_reg, status_next;

    logic                       hold_full;
    logic                       out_free;
    logic                       last_emit;
    logic                       emit_pad;
    logic                       trailer_ok;
    logic [31:0]                len_wide;

    assign hold_full = (hold_count_reg == HW'(BLOCK - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign last_emit = (rem_reg == NW'(1));
    assign emit_pad  = (chk_status_reg == pus_pkg::ST_OK) &&
                       (pus_pkg::BYTE_W'(rem_reg) <= pad_reg);
    assign len_wide  = 32'(chk_len_reg);

    assign stat.out_free  = out_free;
    assign stat.last_emit = last_emit;

    // trailer bytes: window places n-p .. n-1 must all equal p
    always_comb
    begin
        trailer_ok = 1'b1;
        for (int i = 0; i < BLOCK; i++)
        begin
            if ((NW'(i) < rem_reg) &&
                (9'(i) + {1'b0, pad_reg} >= 9'(rem_reg)) &&
                (win_reg[i] != pad_reg))
            begin
                trailer_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        win_next            = win_reg;
        hold_count_next     = hold_count_reg;
        byte_count_next     = byte_count_reg;
        count_overflow_next = count_overflow_reg;
        rem_next            = rem_reg;
        pad_next            = pad_reg;
        chk_status_next     = chk_status_reg;
        chk_len_next        = chk_len_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_byte_next       = out_byte_reg;
        is_padding_next     = is_padding_reg;
        run_end_next        = run_end_reg;
        msg_length_next     = msg_length_reg;
        status_next         = status_reg;

        if (cmd.push || cmd.finish)
        begin
            if (byte_count_reg == LEN_MAX)
            begin
                count_overflow_next = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + LEN_BITS'(1);
            end
        end

        if (cmd.push)
        begin
            if (hold_full)
            begin
                // oldest held byte leaves as a plain beat
                out_valid_next  = 1'b1;
                out_byte_next   = win_reg[0];
                is_padding_next = 1'b0;
                run_end_next    = 1'b0;
                msg_length_next = '0;
                status_next     = pus_pkg::ST_OK;
                for (int i = 0; i < BLOCK - 2; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[BLOCK - 2] = data_byte;
            end
            else
            begin
                win_next[hold_count_reg] = data_byte;
                hold_count_next          = hold_count_reg + HW'(1);
            end
        end

        if (cmd.finish)
        begin
            win_next[hold_count_reg] = data_byte;
            pad_next                 = data_byte;
            rem_next                 = NW'(hold_count_reg) + NW'(1);
        end

        if (cmd.check)
        begin
            chk_len_next = byte_count_reg - LEN_BITS'(pad_reg);
            priority if (count_overflow_reg)
            begin
                chk_status_next = pus_pkg::ST_OVERFLOW;
            end
            else if (byte_count_reg < LEN_BITS'(BLOCK))
            begin
                chk_status_next = pus_pkg::ST_SHORT;
            end
            else if ((pad_reg == '0) || (pad_reg > pus_pkg::BYTE_W'(BLOCK)) ||
                     (pad_reg > pus_pkg::BYTE_W'(rem_reg)) || !trailer_ok)
            begin
                chk_status_next = pus_pkg::ST_BAD_PAD;
            end
            else
            begin
                chk_status_next = pus_pkg::ST_OK;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = emit_pad ? '0 : win_reg[0];
            is_padding_next = emit_pad;
            run_end_next    = last_emit;
            msg_length_next = '0;
            status_next     = pus_pkg::ST_OK;
            if (last_emit)
            begin
                status_next = chk_status_reg;
                if (chk_status_reg == pus_pkg::ST_OK)
                begin
                    msg_length_next = len_wide[pus_pkg::LEN_OUT_W-1:0];
                end
                hold_count_next     = '0;
                byte_count_next     = '0;
                count_overflow_next = 1'b0;
            end
            for (int i = 0; i < BLOCK - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            rem_next = rem_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg     <= '0;
            byte_count_reg     <= '0;
            count_overflow_reg <= 1'b0;
            rem_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            hold_count_reg     <= hold_count_next;
            byte_count_reg     <= byte_count_next;
            count_overflow_reg <= count_overflow_next;
            rem_reg            <= rem_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg        <= win_next;
        pad_reg        <= pad_next;
        chk_status_reg <= chk_status_next;
        chk_len_reg    <= chk_len_next;
        out_byte_reg   <= out_byte_next;
        is_padding_reg <= is_padding_next;
        run_end_reg    <= run_end_next;
        msg_length_reg <= msg_length_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_padding = is_padding_reg;
    assign run_end    = run_end_reg;
    assign msg_length = msg_length_reg;
    assign status     = status_reg;

endmodule

// ===== sv/pus_checker.sv =====
// ----------------------------------------------------------------------------
// pus_checker
// port-level checks of the unpadder, bound to the top level
// ----------------------------------------------------------------------------
module pus_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pus_pkg::BYTE_W-1:0]    out_byte,
    input logic                          is_padding,
    input logic                          run_end,
    input logic [pus_pkg::LEN_OUT_W-1:0] msg_length,
    input logic [1:0]                    status
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output beat changed while stalled");

    // only the closing beat carries length and status
    a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_end |-> status == pus_pkg::ST_OK && msg_length == '0)
        else $error("length or status on a non-final beat");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_padding |-> out_byte == '0)
        else $error("padding beat not zeroed");

    // an error message keeps its bytes and reports no length
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_end && status != pus_pkg::ST_OK
        |-> msg_length == '0 && !is_padding)
        else $error("error beat with length or padding");

    // the trailer check follows the final beat, so no beat is taken next
    a_check_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input taken right after a final beat");

endmodule

bind pkcs7_unpad_stream pus_checker u_pus_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming pkcs7 unpadder: messages are pushed
// byte by byte with random gaps, the output side stalls at random, and every
// accepted output beat is compared with a cycle-free model of the unpadder
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BLOCK      = pus_pkg::BLOCK_DEFAULT;
    localparam int LEN_BITS   = pus_pkg::LEN_BITS_DEFAULT;
    localparam int BYTE_W     = pus_pkg::BYTE_W;
    localparam int LEN_OUT_W  = pus_pkg::LEN_OUT_W;
    localparam int LEN_MAX    = (1 << LEN_BITS) - 1;
    localparam int RAND_BYTES = 500;

    typedef logic [BYTE_W-1:0] octet_q_t[$];

    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic                 pad;
        logic                 fin;
        logic [LEN_OUT_W-1:0] length;
        pus_pkg::status_t     st;
    } unpad_beat_t;

    // model of the unpadder plus the queue of beats it still owes
    class unpad_tracker;
        unpad_beat_t       expected[$];
        logic [BYTE_W-1:0] window[BLOCK-1];
        int                held;
        int unsigned       byte_cnt;
        bit                ovf;
        int                mismatches;

        function new();
            held       = 0;
            byte_cnt   = 0;
            ovf        = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected.size();
        endfunction

        task flag(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        function void absorb_byte(logic [BYTE_W-1:0] b, logic l);
            logic [BYTE_W-1:0] win[BLOCK];
            int                n;
            int                p;
            int                k;
            pus_pkg::status_t  st;
            int unsigned       len;
            unpad_beat_t       e;
            if (byte_cnt >= LEN_MAX)
            begin
                byte_cnt = LEN_MAX;
                ovf      = 1'b1;
            end
            else
                byte_cnt++;
            if (!l)
            begin
                if (held < BLOCK - 1)
                begin
                    window[held] = b;
                    held++;
                    return;
                end
                e.data   = window[0];
                e.pad    = 1'b0;
                e.fin    = 1'b0;
                e.length = '0;
                e.st     = pus_pkg::ST_OK;
                expected.push_back(e);
                for (k = 0; k < BLOCK - 2; k++)
                    window[k] = window[k+1];
                window[BLOCK-2] = b;
                return;
            end
            // final beat: judge the trailer over the held bytes plus this one
            n = held;
            for (k = 0; k < n; k++)
                win[k] = window[k];
            win[n] = b;
            n++;
            p  = b;
            st = pus_pkg::ST_OK;
            if (ovf)
                st = pus_pkg::ST_OVERFLOW;
            else if (byte_cnt < BLOCK)
                st = pus_pkg::ST_SHORT;
            else if (p == 0 || p > BLOCK || p > n)
                st = pus_pkg::ST_BAD_PAD;
            else
                for (k = 0; k < p; k++)
                    if (win[n-1-k] != b)
                        st = pus_pkg::ST_BAD_PAD;
            len = (st == pus_pkg::ST_OK) ? byte_cnt - p : 0;
            for (k = 0; k < n; k++)
            begin
                e.pad    = (st == pus_pkg::ST_OK) && (k >= n - p);
                e.fin    = (k == n - 1);
                e.data   = e.pad ? '0 : win[k];
                e.length = e.fin ? len[LEN_OUT_W-1:0] : '0;
                e.st     = e.fin ? st : pus_pkg::ST_OK;
                expected.push_back(e);
            end
            held     = 0;
            byte_cnt = 0;
            ovf      = 1'b0;
        endfunction

        task match_beat(logic [BYTE_W-1:0] o_byte, logic o_pad, logic o_end,
                        logic [LEN_OUT_W-1:0] o_len, logic [1:0] o_st);
            unpad_beat_t e;
            if (expected.size() == 0)
            begin
                flag($sformatf("output beat %h with nothing pending", o_byte));
                return;
            end
            e = expected.pop_front();
            if (o_byte !== e.data)
                flag($sformatf("out_byte %h, want %h", o_byte, e.data));
            if (o_pad !== e.pad)
                flag($sformatf("is_padding %b, want %b", o_pad, e.pad));
            if (o_end !== e.fin)
                flag($sformatf("run_end %b, want %b", o_end, e.fin));
            if (o_len !== e.length)
                flag($sformatf("msg_length %0d, want %0d", o_len, e.length));
            if (o_st !== e.st)
                flag($sformatf("status %0d, want %s", o_st, e.st.name()));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 is_padding;
    logic                 run_end;
    logic [LEN_OUT_W-1:0] msg_length;
    logic [1:0]           status;

    bit                   quiet = 1'b0;
    int                   bytes_sent = 0;
    unpad_tracker         tracker = new();

    pkcs7_unpad_stream #(
        .BLOCK    (BLOCK),
        .LEN_BITS (LEN_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_padding (is_padding),
        .run_end    (run_end),
        .msg_length (msg_length),
        .status     (status)
    );

    always #2 clk = ~clk;

    // both channels sampled at the edge, before any update of this step lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.absorb_byte(data_byte, last);
            if (out_valid && out_ready)
                tracker.match_beat(out_byte, is_padding, run_end, msg_length, status);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= quiet || ($urandom_range(99, 0) >= 27);
        end
    end

    task automatic push_beat(input logic [BYTE_W-1:0] b, input logic l);
        while (!quiet && $urandom_range(99, 0) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_message(input octet_q_t m);
        int k;
        for (k = 0; k < m.size(); k++)
            push_beat(m[k], k == m.size() - 1);
    endtask

    task automatic append(inout octet_q_t m, input int count, input int v);
        repeat (count)
            m.push_back(v[BYTE_W-1:0]);
    endtask

    task automatic append_random(inout octet_q_t m, input int count);
        repeat (count)
            m.push_back(BYTE_W'($urandom_range(255, 0)));
    endtask

    task automatic compose(output octet_q_t m);
        int kind;
        int body;
        int p;
        int k;
        m    = {};
        kind = $urandom_range(99, 0);
        body = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 0) : $urandom_range(40, 0);
        if (kind < 60)
        begin
            // well-formed, mostly block aligned
            append_random(m, body);
            p = ($urandom_range(3, 0) == 0) ? $urandom_range(BLOCK, 1)
                                            : BLOCK - (body % BLOCK);
            append(m, p, p);
        end
        else if (kind < 78)
        begin
            // one trailer byte other than the last is corrupted
            append_random(m, body);
            p = $urandom_range(BLOCK, 2);
            append(m, p, p);
            k = m.size() - 1 - $urandom_range(p - 1, 1);
            m[k] = m[k] ^ (8'h01 << $urandom_range(7, 0));
        end
        else if (kind < 88)
        begin
            // pad value of zero or above one block
            append_random(m, body + BLOCK);
            p = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(255, BLOCK + 1);
            append(m, $urandom_range(BLOCK, 1), p);
        end
        else if (kind < 94)
        begin
            append_random(m, $urandom_range(BLOCK - 2, 0));
            m.push_back(BYTE_W'(($urandom_range(1, 0) == 0) ? 1 : $urandom_range(255, 0)));
        end
        else
            append_random(m, body + 1);
    endtask

    initial
    begin
        octet_q_t m;
        int       idx;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one block that is all padding
        m = {};
        append(m, BLOCK, BLOCK);
        send_message(m);
        // high data bytes with a single pad byte
        m = {};
        append(m, BLOCK - 1, 8'hff);
        append(m, 1, 1);
        send_message(m);
        // pad value zero
        m = {};
        append_random(m, BLOCK - 1);
        append(m, 1, 0);
        send_message(m);
        // pad value one above the block
        m = {};
        append(m, BLOCK, BLOCK + 1);
        send_message(m);
        // pad value with the top bit set
        m = {};
        append(m, BLOCK, 8'h80);
        send_message(m);
        // trailer with one wrong byte
        m = {};
        append_random(m, 20);
        append(m, 4, 4);
        m[21] = 8'h05;
        send_message(m);
        // single-byte message, then one byte shorter than a block
        m = {};
        append(m, 1, 1);
        send_message(m);
        m = {};
        append(m, BLOCK - 2, 8'h00);
        append(m, 1, 1);
        send_message(m);
        // zero data bytes followed by a full pad block
        m = {};
        append(m, BLOCK, 0);
        append(m, BLOCK, BLOCK);
        send_message(m);

        idx = 0;
        while (bytes_sent < RAND_BYTES)
        begin
            quiet = (idx >= 4 && idx < 10);
            compose(m);
            send_message(m);
            idx++;
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (2 * BLOCK + 8)
            @(posedge clk);
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pus_pkg.sv
sv/pus_ctrl.sv
sv/pus_datapath.sv
sv/pkcs7_unpad_stream.sv
sv/pus_checker.sv
tb/sv/tb_top.sv
